### rtl/core/crtcrf_pkg.sv
// Shared types and constants for the CRT controller register file.
// Register indexes, request codes and the timing-register bundle live here.
// No dependencies.
`default_nettype none

package crtcrf_pkg;

  localparam int REG_COUNT = 20;
  localparam int IDX_W     = 5;

  typedef logic [IDX_W-1:0] reg_idx_t;

  typedef enum logic [1:0] {
    REQ_INDEX_WR  = 2'd0,
    REQ_DATA_WR   = 2'd1,
    REQ_DATA_RD   = 2'd2,
    REQ_STATUS_RD = 2'd3
  } req_t;

  localparam reg_idx_t REG_HTOTAL        = 5'd0;
  localparam reg_idx_t REG_HDISP         = 5'd1;
  localparam reg_idx_t REG_HSYNC         = 5'd2;
  localparam reg_idx_t REG_SYNC_WIDTH    = 5'd3;
  localparam reg_idx_t REG_VTOTAL        = 5'd4;
  localparam reg_idx_t REG_VADJUST       = 5'd5;
  localparam reg_idx_t REG_VDISP         = 5'd6;
  localparam reg_idx_t REG_VSYNC         = 5'd7;
  localparam reg_idx_t REG_MODE          = 5'd8;
  localparam reg_idx_t REG_MAX_RASTER    = 5'd9;
  localparam reg_idx_t REG_CURSOR_START  = 5'd10;
  localparam reg_idx_t REG_CURSOR_END    = 5'd11;
  localparam reg_idx_t REG_START_HI      = 5'd12;
  localparam reg_idx_t REG_START_LO      = 5'd13;
  localparam reg_idx_t REG_CURSOR_HI     = 5'd14;
  localparam reg_idx_t REG_CURSOR_LO     = 5'd15;
  localparam reg_idx_t REG_PEN_HI        = 5'd16;
  localparam reg_idx_t REG_PEN_LO        = 5'd17;
  localparam reg_idx_t REG_UPDATE_HI     = 5'd18;
  localparam reg_idx_t REG_UPDATE_LO     = 5'd19;
  localparam reg_idx_t REG_UPDATE_STROBE = 5'd31;

  localparam logic signed [9:0] HOFF_NO_SYNC = -10'sd24;
  localparam logic [9:0]        HOFF_BIAS    = 10'd23;
  localparam logic [7:0]        VOFF_MAX     = 8'd128;

  typedef struct packed {
    logic [7:0] htotal;
    logic [7:0] hsync;
    logic [7:0] vtotal;
    logic [7:0] vadjust;
    logic [7:0] vsync;
    logic [3:0] max_raster;
  } timing_t;

endpackage

`default_nettype wire

### rtl/core/crtcrf_offsets.sv
// Display offset calculation from the timing registers.
// Combinational; uses crtcrf_pkg for the timing bundle and constants.
`default_nettype none

module crtcrf_offsets (
  input  var crtcrf_pkg::timing_t timing,
  output logic signed [9:0]       hoff,
  output logic [7:0]              voff
);

  logic signed [8:0]  vdiff;
  logic signed [14:0] vdiff_ext;
  logic signed [14:0] lines_ext;
  logic signed [14:0] vprod;
  logic signed [14:0] vsum;
  logic [4:0]         lines;

  always_comb begin
    if (timing.hsync != 8'd0) begin
      hoff = {2'b00, timing.htotal} - {2'b00, timing.hsync} - crtcrf_pkg::HOFF_BIAS;
    end else begin
      hoff = crtcrf_pkg::HOFF_NO_SYNC;
    end
  end

  assign lines     = {1'b0, timing.max_raster} + 5'd1;
  assign vdiff     = $signed({1'b0, timing.vtotal}) - $signed({1'b0, timing.vsync});
  assign vdiff_ext = {{6{vdiff[8]}}, vdiff};
  assign lines_ext = {10'd0, lines};
  assign vprod     = vdiff_ext * lines_ext;
  assign vsum      = vprod + $signed({7'd0, timing.vadjust});

  always_comb begin
    if (vsum < 15'sd0) begin
      voff = 8'd0;
    end else if (vsum > $signed({7'd0, crtcrf_pkg::VOFF_MAX})) begin
      voff = crtcrf_pkg::VOFF_MAX;
    end else begin
      voff = vsum[7:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/crtc_register_file_lightpen.sv
// Register file of a 6545-style CRT controller with light-pen capture.
// Accepts one request per cycle unless the result output is stalled.
// The request register feeds the register bank update and the result register.
// Reset clears every bank register, the index, both status flags and both offsets.
// Depends on crtcrf_pkg and crtcrf_offsets.
`default_nettype none

module crtc_register_file_lightpen (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // wdata[7:0], key_hit[8], vblank_now[9], zero pad
  input  wire logic [1:0]  s_tuser,  // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata   // rdata, scan_address, scan_valid, horiz_offset,
                                     // vert_offset, zero pad
);

  logic                 in_valid;
  crtcrf_pkg::req_t     in_req;
  logic [7:0]           in_wdata;
  logic                 in_key;
  logic                 in_vblank;

  logic [7:0]           bank [crtcrf_pkg::REG_COUNT];
  logic [7:0]           bank_next [crtcrf_pkg::REG_COUNT];
  crtcrf_pkg::reg_idx_t reg_index;
  crtcrf_pkg::reg_idx_t reg_index_next;
  logic                 pen_full;
  logic                 pen_full_next;
  logic                 upd_flag;
  logic                 upd_flag_next;
  logic signed [9:0]    hoff_reg;
  logic [7:0]           voff_reg;

  logic                 out_free;
  logic                 work;
  logic                 timing_write;
  logic                 strobe;
  logic [7:0]           wr_value;
  logic [13:0]          scan_addr;
  logic [7:0]           rd;
  logic [13:0]          saddr;
  logic                 svalid;
  crtcrf_pkg::timing_t  timing_next;
  logic signed [9:0]    hoff_calc;
  logic [7:0]           voff_calc;
  logic signed [9:0]    hoff_out;
  logic [7:0]           voff_out;

  assign out_free = !m_tvalid || m_tready;
  assign work     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req    <= crtcrf_pkg::req_t'(s_tuser);
      in_wdata  <= s_tdata[7:0];
      in_key    <= s_tdata[8];
      in_vblank <= s_tdata[9];
    end
  end

  assign scan_addr = {bank[crtcrf_pkg::REG_UPDATE_HI][5:0], bank[crtcrf_pkg::REG_UPDATE_LO]};
  assign wr_value  = (reg_index == crtcrf_pkg::REG_MAX_RASTER) ? {4'd0, in_wdata[3:0]}
                                                                : in_wdata;

  always_comb begin
    bank_next      = bank;
    reg_index_next = reg_index;
    pen_full_next  = pen_full;
    upd_flag_next  = upd_flag;
    timing_write   = 1'b0;
    strobe         = 1'b0;
    rd             = 8'd0;
    saddr          = 14'd0;
    svalid         = 1'b0;
    unique case (in_req)
      crtcrf_pkg::REQ_INDEX_WR: begin
        reg_index_next = in_wdata[4:0];
      end
      crtcrf_pkg::REQ_DATA_WR: begin
        unique case (reg_index) inside
          crtcrf_pkg::REG_HTOTAL, crtcrf_pkg::REG_HSYNC, crtcrf_pkg::REG_VTOTAL,
          crtcrf_pkg::REG_VADJUST, crtcrf_pkg::REG_VSYNC,
          crtcrf_pkg::REG_MAX_RASTER: begin
            if (bank[reg_index] != wr_value) begin
              bank_next[reg_index] = wr_value;
              timing_write         = 1'b1;
            end
          end
          crtcrf_pkg::REG_START_HI, crtcrf_pkg::REG_CURSOR_HI,
          crtcrf_pkg::REG_UPDATE_HI: begin
            bank_next[reg_index] = {2'b00, in_wdata[5:0]};
          end
          crtcrf_pkg::REG_HDISP, crtcrf_pkg::REG_SYNC_WIDTH, crtcrf_pkg::REG_VDISP,
          crtcrf_pkg::REG_MODE, crtcrf_pkg::REG_CURSOR_START, crtcrf_pkg::REG_CURSOR_END,
          crtcrf_pkg::REG_START_LO, crtcrf_pkg::REG_CURSOR_LO,
          crtcrf_pkg::REG_UPDATE_LO: begin
            bank_next[reg_index] = in_wdata;
          end
          crtcrf_pkg::REG_UPDATE_STROBE: begin
            strobe = 1'b1;
          end
          default: begin
          end
        endcase
      end
      crtcrf_pkg::REQ_DATA_RD: begin
        unique case (reg_index) inside
          crtcrf_pkg::REG_CURSOR_HI, crtcrf_pkg::REG_CURSOR_LO,
          crtcrf_pkg::REG_UPDATE_HI, crtcrf_pkg::REG_UPDATE_LO: begin
            rd = bank[reg_index];
          end
          crtcrf_pkg::REG_PEN_HI, crtcrf_pkg::REG_PEN_LO: begin
            rd            = bank[reg_index];
            pen_full_next = 1'b0;
            upd_flag_next = 1'b0;
          end
          crtcrf_pkg::REG_UPDATE_STROBE: begin
            strobe = 1'b1;
          end
          default: begin
          end
        endcase
      end
      crtcrf_pkg::REQ_STATUS_RD: begin
        rd = {upd_flag, pen_full, in_vblank, 5'd0};
      end
      default: begin
      end
    endcase
    if (strobe) begin
      saddr         = scan_addr;
      svalid        = 1'b1;
      upd_flag_next = 1'b1;
      if (in_key) begin
        bank_next[crtcrf_pkg::REG_PEN_LO] = scan_addr[7:0];
        bank_next[crtcrf_pkg::REG_PEN_HI] = {6'd0, scan_addr[9:8]};
        pen_full_next                     = 1'b1;
      end
    end
  end

  always_comb begin
    timing_next.htotal     = bank_next[crtcrf_pkg::REG_HTOTAL];
    timing_next.hsync      = bank_next[crtcrf_pkg::REG_HSYNC];
    timing_next.vtotal     = bank_next[crtcrf_pkg::REG_VTOTAL];
    timing_next.vadjust    = bank_next[crtcrf_pkg::REG_VADJUST];
    timing_next.vsync      = bank_next[crtcrf_pkg::REG_VSYNC];
    timing_next.max_raster = bank_next[crtcrf_pkg::REG_MAX_RASTER][3:0];
  end

  crtcrf_offsets u_offsets (
    .timing (timing_next),
    .hoff   (hoff_calc),
    .voff   (voff_calc)
  );

  assign hoff_out = timing_write ? hoff_calc : hoff_reg;
  assign voff_out = timing_write ? voff_calc : voff_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < crtcrf_pkg::REG_COUNT; i++) begin
        bank[i] <= 8'd0;
      end
      reg_index <= '0;
      pen_full  <= 1'b0;
      upd_flag  <= 1'b0;
      hoff_reg  <= '0;
      voff_reg  <= 8'd0;
    end else if (work) begin
      bank      <= bank_next;
      reg_index <= reg_index_next;
      pen_full  <= pen_full_next;
      upd_flag  <= upd_flag_next;
      hoff_reg  <= hoff_out;
      voff_reg  <= voff_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      m_tdata <= {7'd0, voff_out, hoff_out, svalid, saddr, rd};
    end
  end

endmodule

`default_nettype wire
